// ===== hdl/sia_pkg.sv =====
package sia_pkg;

  localparam int SLOTS_DEFAULT = 1024;

  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOLIVE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] slot_index;
  } sia_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  granted_index;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  live_count;
  } sia_out_t;

endpackage

// ===== hdl/slot_index_allocator_top.sv =====
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   sia_in_t  (kind, slot_index)
// out       output     out_valid/out_stall sia_out_t (granted_index, status, live_count)
// cfg       input      cfg_write           cfg_data  (pool_limit)
//
// Each request is accepted in S_IDLE, then executed in S_EXEC, when the
// link memory read of the free-list head has returned.
// Execute holds while the output register is full and stalled.
// rst is synchronous; it empties the free list, zeroes the live count, sets the limit to
// LIMIT_RESET and clears handshake state. The link memory is not cleared.
module slot_index_allocator_top #(
  parameter int SLOTS = sia_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sia_pkg::sia_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sia_pkg::sia_out_t              out_data,
  input  logic                           cfg_write,
  input  logic [sia_pkg::COUNT_W-1:0]    cfg_data
);

  localparam int HW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam int EW = HW + 11;
  localparam logic [HW-1:0] HEAD_EMPTY = HW'(SLOTS);
  localparam logic [EW-1:0] SLOTS_E    = EW'(SLOTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                        state;
  sia_pkg::sia_in_t            req;
  logic [HW-1:0]               free_head, free_head_next;
  logic [HW-1:0]               live_slots, live_slots_next;
  logic [sia_pkg::COUNT_W-1:0] pool_limit;

  logic [HW-1:0] next_link [SLOTS];
  logic [HW-1:0] rd_link;
  logic          rd_en;
  logic          mem_we;
  logic [IW-1:0] wr_addr;

  logic [EW-1:0] head_e, live_e, lim_e, eff_e, link_e, idx_e, granted_e;
  logic [EW-1:0] live_next_e;
  logic          head_empty;
  logic          can_load;
  logic          accept;
  logic [sia_pkg::STATUS_W-1:0] status;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;

  assign head_e      = {11'b0, free_head};
  assign live_e      = {11'b0, live_slots};
  assign live_next_e = {11'b0, live_slots_next};
  assign lim_e       = {{HW{1'b0}}, pool_limit};
  assign eff_e       = (lim_e < SLOTS_E) ? lim_e : SLOTS_E;
  assign link_e      = {11'b0, rd_link};
  assign idx_e       = {{(EW - sia_pkg::INDEX_W){1'b0}}, req.slot_index};
  assign head_empty  = (head_e >= SLOTS_E);

  // link of the current head is fetched as the allocate is accepted
  assign rd_en = accept && (in_data.kind == sia_pkg::KIND_ALLOC) && !head_empty;

  always_comb begin
    free_head_next  = free_head;
    live_slots_next = live_slots;
    granted_e       = '0;
    status          = sia_pkg::STAT_OK;
    mem_we          = 1'b0;
    wr_addr         = idx_e[IW-1:0];
    unique case (req.kind)
      sia_pkg::KIND_ALLOC: begin
        if (!head_empty) begin
          granted_e      = head_e;
          free_head_next = (link_e < SLOTS_E) ? rd_link : HEAD_EMPTY;
          if (live_e < SLOTS_E) begin
            live_slots_next = live_slots + HW'(1);
          end
        end else if (live_e < eff_e) begin
          granted_e       = live_e;
          live_slots_next = live_slots + HW'(1);
        end else begin
          status = sia_pkg::STAT_FULL;
        end
      end
      sia_pkg::KIND_FREE: begin
        if ((live_slots == '0) || (idx_e >= SLOTS_E)) begin
          status = sia_pkg::STAT_NOLIVE;
        end else begin
          mem_we          = 1'b1;
          free_head_next  = idx_e[HW-1:0];
          live_slots_next = live_slots - HW'(1);
        end
      end
      sia_pkg::KIND_CLEAR: begin
        free_head_next  = HEAD_EMPTY;
        live_slots_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && can_load && mem_we) begin
      next_link[wr_addr] <= free_head;
    end
    if (rd_en) begin
      rd_link <= next_link[free_head[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (state == S_EXEC && can_load) begin
      out_data.granted_index <= granted_e[sia_pkg::INDEX_W-1:0];
      out_data.status        <= status;
      out_data.live_count    <= live_next_e[sia_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_head  <= HEAD_EMPTY;
      live_slots <= '0;
      pool_limit <= sia_pkg::LIMIT_RESET;
    end else begin
      if (cfg_write) begin
        pool_limit <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (can_load) begin
            free_head  <= free_head_next;
            live_slots <= live_slots_next;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request accepted while another is in flight");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result appeared without an execute cycle");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_e <= SLOTS_E)
    else $error("live count above pool size");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head_e <= SLOTS_E)
    else $error("free-list head out of range");

endmodule
